/* src/string_pattern_matcher_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the string pattern matcher
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef STRING_PATTERN_MATCHER_CORE_ASSERT_SVH
`define STRING_PATTERN_MATCHER_CORE_ASSERT_SVH

// same-cycle implication
`define SPM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/spm_pkg.sv */
// ----------------------------------------------------------------------------
// spm_pkg
// Types, constants and helper functions for the string pattern matcher.
// ----------------------------------------------------------------------------
package spm_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int POS_BITS_DEF    = 16;
	localparam int PATTERN_BYTES   = 16;  // bytes held by the two pattern registers
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_INDEX_W     = 3;
	localparam int FIELD_POS_W     = 16;  // width of search_from and match_pos

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LOW    = 3'd0,
		CFG_PATTERN_HIGH   = 3'd1,
		CFG_PATTERN_LENGTH = 3'd2,
		CFG_CASE_SENSITIVE = 3'd3,
		CFG_WHOLE_WORD     = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [7:0]             text_byte;
		logic                   first_byte;
		logic                   final_byte;
		logic [FIELD_POS_W-1:0] search_from;
	} in_item_t;

	typedef struct packed {
		logic                   found;
		logic [FIELD_POS_W-1:0] match_pos;
	} out_item_t;

	typedef struct packed {
		logic hit;         // pattern equals the newest bytes of the window
		logic left_white;  // byte just before the aligned match is whitespace
	} cmp_res_t;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
		if (!cs && c >= 8'h61 && c <= 8'h7A)
			return c - 8'h20;
		return c;
	endfunction

	function automatic logic is_white(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

/* src/spm_window_cmp.sv */
// ----------------------------------------------------------------------------
// spm_window_cmp
// Compares the pattern against the newest bytes of the character window.
// ----------------------------------------------------------------------------
module spm_window_cmp import spm_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic [MAX_PATTERN:0][7:0]          win,
	input  logic [2*CFG_DATA_W-1:0]            pattern,
	input  logic [$clog2(MAX_PATTERN+1)-1:0]   len,
	input  logic                               case_sensitive,
	output cmp_res_t                           res
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [MAX_PATTERN-1:0][7:0] pat_b;
	logic [MAX_PATTERN-1:0]      ok;

	// pattern bytes past the register contents read as zero
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (i < PATTERN_BYTES)
				pat_b[i] = pattern[8*(i%PATTERN_BYTES) +: 8];
			else
				pat_b[i] = 8'h00;
		end
	end

	// window entry k lines up with pattern byte len-1-k
	always_comb begin
		logic [LEN_W-1:0] j;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			j = len - LEN_W'(1) - LEN_W'(k);
			ok[k] = (k >= int'(len)) ||
				(fold(win[k], case_sensitive) == fold(pat_b[j[IDX_W-1:0]], case_sensitive));
		end
	end

	assign res.hit        = &ok;
	assign res.left_white = is_white(win[len]);

endmodule

/* src/string_pattern_matcher_core.sv */
// ----------------------------------------------------------------------------
// string_pattern_matcher_core: streaming pattern search, one text byte per transfer
// An input transfer reaches out_valid through the input register, then the result register.
// Throughput: one byte per cycle, set by the window compare between the two registers;
// a stalled result holds the input register and stalls the input.
// Reset: arst_n clears control, window, position state and config to defaults.
// ----------------------------------------------------------------------------
`include "string_pattern_matcher_core_assert.svh"

module string_pattern_matcher_core import spm_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int POS_BITS    = POS_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	// text byte channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_item,
	// result channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_item
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	logic [CFG_DATA_W-1:0] pattern_low_q;
	logic [CFG_DATA_W-1:0] pattern_high_q;
	logic [4:0]            pattern_length_q;
	logic                  case_sensitive_q;
	logic                  whole_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= 5'd1;
			case_sensitive_q <= 1'b1;
			whole_word_q     <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PATTERN_LOW:    pattern_low_q    <= cfg_wdata;
				CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_wdata;
				CFG_PATTERN_LENGTH: pattern_length_q <= cfg_wdata[4:0];
				CFG_CASE_SENSITIVE: case_sensitive_q <= cfg_wdata[0];
				CFG_WHOLE_WORD:     whole_word_q     <= cfg_wdata[0];
				default:            ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// Clamp the length: zero acts as one, anything above the window acts as the maximum.
	logic [LEN_W-1:0] len_eff;
	always_comb begin
		if (pattern_length_q == 5'd0)
			len_eff = LEN_W'(1);
		else if (int'(pattern_length_q) > MAX_PATTERN)
			len_eff = LEN_W'(MAX_PATTERN);
		else
			len_eff = LEN_W'(pattern_length_q);
	end

	// ------------------------------------------------------------------------
	// Input register and handshake
	// ------------------------------------------------------------------------
	logic     valid_s1;
	in_item_t item_s1;
	logic     advance;   // result slot is free or is being emptied this cycle
	logic     process;   // the byte in the input register is consumed this edge

	assign advance  = !out_valid || !out_stall;
	assign process  = valid_s1 && advance;
	// Take a new byte whenever the input register is empty or draining.
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// ------------------------------------------------------------------------
	// Search state
	// ------------------------------------------------------------------------
	logic [MAX_PATTERN:0][7:0] win_q;       // entry 0 is the newest byte
	logic [POS_BITS-1:0]       pos_q;       // index of the next byte
	logic [POS_BITS-1:0]       lim_q;       // lowest allowed match start
	logic                      done_q;      // this text already gave its result
	logic                      pend_v_q;    // whole-word match waiting on its right side
	logic [POS_BITS-1:0]       pend_pos_q;

	// A first byte restarts the text before anything else is looked at.
	logic [MAX_PATTERN:0][7:0] win_e;
	logic [POS_BITS-1:0]       pos_e;
	logic [POS_BITS-1:0]       lim_e;
	logic                      done_e;
	logic                      pend_v_e;
	logic [POS_BITS-1:0]       pend_pos_e;
	logic [POS_BITS-1:0]       lim_in;

	always_comb begin
		for (int i = 0; i < POS_BITS; i++)
			lim_in[i] = (i < FIELD_POS_W) ? item_s1.search_from[i % FIELD_POS_W] : 1'b0;
	end

	always_comb begin
		if (item_s1.first_byte) begin
			win_e      = '0;
			pos_e      = '0;
			lim_e      = lim_in;
			done_e     = 1'b0;
			pend_v_e   = 1'b0;
			pend_pos_e = '0;
		end else begin
			win_e      = win_q;
			pos_e      = pos_q;
			lim_e      = lim_q;
			done_e     = done_q;
			pend_v_e   = pend_v_q;
			pend_pos_e = pend_pos_q;
		end
	end

	// Shift the new byte into the window.
	logic [MAX_PATTERN:0][7:0] win_n;
	always_comb begin
		win_n[0] = item_s1.text_byte;
		for (int i = 1; i <= MAX_PATTERN; i++)
			win_n[i] = win_e[i-1];
	end

	cmp_res_t cmp;

	spm_window_cmp #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_cmp (
		.win            (win_n),
		.pattern        ({pattern_high_q, pattern_low_q}),
		.len            (len_eff),
		.case_sensitive (case_sensitive_q),
		.res            (cmp)
	);

	// ------------------------------------------------------------------------
	// Match decision
	// ------------------------------------------------------------------------
	logic                over;       // position has saturated: no match may end here
	logic [POS_BITS:0]   end_sum;    // position + 1, one bit wider
	logic [POS_BITS:0]   start_wide;
	logic [POS_BITS-1:0] start_pos;
	logic                span_ok;    // enough bytes seen for the whole pattern
	logic                confirm;    // pending whole-word match sees whitespace
	logic                cand;       // aligned match that clears the start limit
	logic                have;
	logic                found;
	logic [POS_BITS-1:0] mpos;
	logic                pend_v_n;
	logic [POS_BITS-1:0] pend_pos_n;

	assign over       = (pos_e == POS_MAX);
	assign end_sum    = {1'b0, pos_e} + (POS_BITS+1)'(1);
	assign span_ok    = end_sum >= (POS_BITS+1)'(len_eff);
	assign start_wide = end_sum - (POS_BITS+1)'(len_eff);
	assign start_pos  = start_wide[POS_BITS-1:0];
	assign confirm    = pend_v_e && is_white(item_s1.text_byte);
	assign cand       = !confirm && !over && span_ok && (start_pos >= lim_e) && cmp.hit;

	always_comb begin
		have       = 1'b0;
		found      = 1'b0;
		mpos       = '0;
		pend_v_n   = 1'b0;
		pend_pos_n = pend_pos_e;
		priority if (confirm) begin
			have  = 1'b1;
			found = 1'b1;
			mpos  = pend_pos_e;
		end else if (cand && !whole_word_q) begin
			have  = 1'b1;
			found = 1'b1;
			mpos  = start_pos;
		end else if (cand && (start_pos == '0 || cmp.left_white)) begin
			// whole word: a final byte closes the right side, otherwise wait
			if (item_s1.final_byte) begin
				have  = 1'b1;
				found = 1'b1;
				mpos  = start_pos;
			end else begin
				pend_v_n   = 1'b1;
				pend_pos_n = start_pos;
			end
		end else begin
		end
		if (!have && item_s1.final_byte) begin
			have  = 1'b1;
			found = 1'b0;
			mpos  = '0;
		end
	end

	logic [FIELD_POS_W-1:0] mpos_field;
	always_comb begin
		for (int i = 0; i < FIELD_POS_W; i++)
			mpos_field[i] = (i < POS_BITS) ? mpos[i % POS_BITS] : 1'b0;
	end

	// ------------------------------------------------------------------------
	// State update
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			pos_q      <= '0;
			lim_q      <= '0;
			done_q     <= 1'b0;
			pend_v_q   <= 1'b0;
			pend_pos_q <= '0;
		end else if (process) begin
			if (done_e) begin
				// hold everything but what a first byte has cleared
				win_q      <= win_e;
				pos_q      <= pos_e;
				lim_q      <= lim_e;
				done_q     <= done_e;
				pend_v_q   <= pend_v_e;
				pend_pos_q <= pend_pos_e;
			end else begin
				win_q      <= win_n;
				pos_q      <= over ? pos_e : end_sum[POS_BITS-1:0];
				lim_q      <= lim_e;
				done_q     <= have;
				pend_v_q   <= have ? 1'b0 : pend_v_n;
				pend_pos_q <= pend_pos_n;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------------
	logic      res_valid_q;
	out_item_t res_q;
	logic      emit;

	assign emit = !done_e && have;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (process) begin
			res_valid_q <= emit;
		end else if (out_valid && !out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && emit) begin
			res_q.found     <= found;
			res_q.match_pos <= mpos_field;
		end
	end

	assign out_valid = res_valid_q;
	assign out_item  = res_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`SPM_ASSERT_NOW(a_notfound_pos_zero, clk, arst_n, out_valid && !out_item.found, out_item.match_pos == '0, "not-found result carries a nonzero position")
	`SPM_ASSERT_NOW(a_done_no_pending, clk, arst_n, done_q, !pend_v_q, "pending whole-word match left after the result")
	`SPM_ASSERT_NOW(a_done_silent, clk, arst_n, process && done_q && !item_s1.first_byte, !emit, "second result for one text")
	`SPM_ASSERT_NEXT(a_result_sets_done, clk, arst_n, process && emit, done_q, "result given without closing the text")

endmodule

/* tb/match_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// match_checker
// Watches the register port and both channels of the pattern matcher, keeps
// its own search state, predicts each result and compares it on arrival.
// ----------------------------------------------------------------------------
module match_checker import spm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  in_item_t               in_item,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  out_item_t              out_item,
	output int                     mismatch_count,
	output int                     results_due,
	output int                     bytes_searched
);

	localparam int WIN = MAX_PATTERN_DEF + 1;

	// register copies
	logic [63:0] pat_lo, pat_hi;
	logic [4:0]  pat_len;
	logic        case_exact, word_mode;

	// search state
	logic [7:0]  history [WIN];
	logic [15:0] next_pos, min_start, held_pos;
	logic        text_closed, held;

	out_item_t   due_results [$];
	int          n_err, n_live;

	function automatic logic [7:0] upper(input logic [7:0] c);
		if (!case_exact && c >= 8'h61 && c <= 8'h7A)
			return c - 8'h20;
		return c;
	endfunction

	function automatic logic blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [7:0] pattern_at(input int k);
		logic [127:0] both;
		both = {pat_hi, pat_lo};
		return both[8*k +: 8];
	endfunction

	function automatic int used_len();
		if (pat_len == 5'd0)
			return 1;
		if (int'(pat_len) > MAX_PATTERN_DEF)
			return MAX_PATTERN_DEF;
		return int'(pat_len);
	endfunction

	task automatic advance_search(input in_item_t it);
		logic [15:0] p, s, mpos;
		logic        over, have, hit, same;
		int          len, k;
		out_item_t   r;
		// count every accepted byte, answered text or not
		n_live++;
		if (it.first_byte) begin
			for (k = 0; k < WIN; k++)
				history[k] = 8'h00;
			next_pos    = 16'd0;
			min_start   = it.search_from;
			text_closed = 1'b0;
			held        = 1'b0;
			held_pos    = 16'd0;
		end
		// text already answered: drop the byte
		if (text_closed)
			return;
		p    = next_pos;
		over = (p == 16'hFFFF);
		for (k = WIN - 1; k > 0; k--)
			history[k] = history[k-1];
		history[0] = it.text_byte;
		have = 1'b0;
		hit  = 1'b0;
		mpos = 16'd0;
		// a whole-word hit waits for its right side
		if (held) begin
			held = 1'b0;
			if (blank(it.text_byte)) begin
				have = 1'b1;
				hit  = 1'b1;
				mpos = held_pos;
			end
		end
		len = used_len();
		if (!have && !over && int'(p) + 1 >= len) begin
			s = p + 16'd1 - 16'(len);
			if (s >= min_start) begin
				same = 1'b1;
				for (k = 0; k < len; k++)
					if (upper(history[k]) != upper(pattern_at(len - 1 - k)))
						same = 1'b0;
				if (same) begin
					if (!word_mode) begin
						have = 1'b1;
						hit  = 1'b1;
						mpos = s;
					end else if (s == 16'd0 || blank(history[len])) begin
						if (it.final_byte) begin
							have = 1'b1;
							hit  = 1'b1;
							mpos = s;
						end else begin
							held     = 1'b1;
							held_pos = s;
						end
					end
				end
			end
		end
		if (!have && it.final_byte) begin
			have = 1'b1;
			hit  = 1'b0;
			mpos = 16'd0;
		end
		if (!over)
			next_pos = p + 16'd1;
		if (have) begin
			text_closed = 1'b1;
			held        = 1'b0;
			r.found     = hit;
			r.match_pos = mpos;
			due_results.push_back(r);
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (due_results.size() == 0) begin
			n_err++;
			$display("%0t: unexpected result, expected none, got found=%0b pos=%0d",
				$time, got.found, got.match_pos);
			return;
		end
		want = due_results.pop_front();
		if (got.found !== want.found) begin
			n_err++;
			$display("%0t: found mismatch, expected %0b, got %0b",
				$time, want.found, got.found);
		end
		if (got.match_pos !== want.match_pos) begin
			n_err++;
			$display("%0t: match_pos mismatch, expected %0d, got %0d",
				$time, want.match_pos, got.match_pos);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo      = 64'd0;
			pat_hi      = 64'd0;
			pat_len     = 5'd1;
			case_exact  = 1'b1;
			word_mode   = 1'b0;
			for (int k = 0; k < WIN; k++)
				history[k] = 8'h00;
			next_pos    = 16'd0;
			min_start   = 16'd0;
			text_closed = 1'b0;
			held        = 1'b0;
			held_pos    = 16'd0;
			due_results.delete();
			n_err       = 0;
			n_live      = 0;
		end else begin
			// results leave before this edge's byte can add one
			if (out_valid && !out_stall)
				check_result(out_item);
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_PATTERN_LOW:    pat_lo     = cfg_wdata;
					CFG_PATTERN_HIGH:   pat_hi     = cfg_wdata;
					CFG_PATTERN_LENGTH: pat_len    = cfg_wdata[4:0];
					CFG_CASE_SENSITIVE: case_exact = cfg_wdata[0];
					CFG_WHOLE_WORD:     word_mode  = cfg_wdata[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				advance_search(in_item);
		end
		mismatch_count <= n_err;
		results_due    <= due_results.size();
		bytes_searched <= n_live;
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the pattern matcher with directed texts and random texts under
// several register settings and idle/stall mixes; the checker beside the
// block grades results.
// ----------------------------------------------------------------------------
module testbench;
	import spm_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int BYTES_PER_SET = 100;  // accepted bytes per register setting

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   in_valid;
	logic                   in_stall;
	in_item_t               in_item;
	logic                   out_valid;
	logic                   out_stall;
	out_item_t              out_item;

	int mismatch_count, results_due, bytes_searched;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	// stimulus-side copy of the active pattern
	logic [7:0] pat [16];
	int         eff_len = 1;
	logic       cur_cs = 1'b1;
	logic       cur_ww = 1'b0;

	string_pattern_matcher_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	match_checker u_match_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_item       (out_item),
		.mismatch_count (mismatch_count),
		.results_due    (results_due),
		.bytes_searched (bytes_searched)
	);

	always #1 clk = ~clk;

	// receiver back-pressure, redrawn every falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// hard stop for a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one byte from a falling edge and hold it until the transfer;
	// returns at the falling edge after the transfer. Sender gaps go first.
	task automatic put_byte(input logic [7:0] c, input logic first, input logic last,
			input logic [15:0] from);
		in_item_t it;
		it.text_byte   = c;
		it.first_byte  = first;
		it.final_byte  = last;
		it.search_from = from;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid, wait for every predicted result, then let the pipeline
	// drain bytes that produce nothing before touching registers.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_regs(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] len, input logic cs, input logic ww);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_PATTERN_LOW;
		cfg_wdata <= lo;
		@(negedge clk);
		cfg_index <= CFG_PATTERN_HIGH;
		cfg_wdata <= hi;
		@(negedge clk);
		cfg_index <= CFG_PATTERN_LENGTH;
		cfg_wdata <= 64'(len);
		@(negedge clk);
		cfg_index <= CFG_CASE_SENSITIVE;
		cfg_wdata <= 64'(cs);
		@(negedge clk);
		cfg_index <= CFG_WHOLE_WORD;
		cfg_wdata <= 64'(ww);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		for (int k = 0; k < 8; k++) begin
			pat[k]     = lo[8*k +: 8];
			pat[k + 8] = hi[8*k +: 8];
		end
		eff_len = (len == 5'd0) ? 1 : (len > 5'd16 ? 16 : int'(len));
		cur_cs  = cs;
		cur_ww  = ww;
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(5))
			0:       return 8'h09;
			1:       return 8'h0A;
			2:       return 8'h0B;
			3:       return 8'h0C;
			4:       return 8'h0D;
			default: return 8'h20;
		endcase
	endfunction

	function automatic logic [7:0] flip_case(input logic [7:0] c);
		if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
			return c ^ 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] pattern_char();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return (8'h41 + 8'($urandom_range(25))) | ($urandom_range(1) ? 8'h20 : 8'h00);
			5:             return 8'h30 + 8'($urandom_range(9));
			6:             return pick_blank();
			default:       return 8'($urandom_range(255));
		endcase
	endfunction

	// text bytes lean on pattern bytes so partial matches are common
	function automatic logic [7:0] filler();
		case ($urandom_range(9))
			0, 1, 2, 3: return pat[$urandom_range(eff_len - 1)];
			4, 5:       return flip_case(pat[$urandom_range(eff_len - 1)]);
			6:          return pick_blank();
			7:          return pattern_char();
			default:    return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic run_text();
		logic [7:0]  txt [$];
		int          n, at, k;
		logic [15:0] from;
		logic        first, last;
		// noise: loose bytes with random marks
		if ($urandom_range(19) == 0) begin
			repeat ($urandom_range(1, 6))
				put_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 16'($urandom_range(65535)));
			return;
		end
		n = ($urandom_range(7) == 0) ? $urandom_range(1, eff_len) : eff_len + $urandom_range(0, 20);
		for (k = 0; k < n; k++)
			txt.push_back(filler());
		at = 0;
		// plant one occurrence, sometimes with letters flipped
		if (n >= eff_len && $urandom_range(9) < 7) begin
			at = $urandom_range(0, n - eff_len);
			for (k = 0; k < eff_len; k++)
				txt[at + k] = ($urandom_range(3) == 0) ? flip_case(pat[k]) : pat[k];
			if (cur_ww && $urandom_range(3) != 0) begin
				if (at > 0)
					txt[at - 1] = pick_blank();
				if (at + eff_len < n)
					txt[at + eff_len] = pick_blank();
			end
		end
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: from = 16'd0;
			6:                from = 16'(at);
			7:                from = 16'(at + 1);
			8:                from = 16'($urandom_range(0, n));
			default:          from = 16'($urandom_range(65535));
		endcase
		first = ($urandom_range(9) != 0);
		last  = ($urandom_range(9) != 0);
		for (k = 0; k < n; k++)
			put_byte(txt[k], (k == 0) && first, (k == n - 1) && last,
				(k == 0) ? from : 16'($urandom_range(65535)));
	endtask

	task automatic pick_setting(input int phase, input int j);
		logic [7:0]  b [16];
		logic [4:0]  len;
		logic        cs, ww;
		logic [63:0] lo, hi;
		for (int k = 0; k < 16; k++)
			b[k] = pattern_char();
		case ($urandom_range(7))
			0:       len = 5'd1;
			1:       len = 5'd16;
			2:       len = 5'd0;
			3:       len = 5'($urandom_range(17, 31));
			default: len = 5'($urandom_range(2, 6));
		endcase
		// each phase opens on a length extreme
		if (j == 0) begin
			case (phase)
				0:       len = 5'd16;
				1:       len = 5'd0;
				2:       len = 5'd31;
				default: len = 5'd1;
			endcase
		end
		cs = 1'($urandom_range(1));
		ww = 1'($urandom_range(1));
		// walk all mode pairs across the phases
		if (j == 1) begin
			cs = phase[0];
			ww = phase[1];
		end
		for (int k = 0; k < 8; k++) begin
			lo[8*k +: 8] = b[k];
			hi[8*k +: 8] = b[k + 8];
		end
		load_regs(lo, hi, len, cs, ww);
	endtask

	initial begin
		int target;
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_PATTERN_LOW;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		in_item   = '0;
		out_stall = 1'b0;
		for (int k = 0; k < 16; k++)
			pat[k] = 8'h00;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, no first mark: pattern is one zero byte at position 1,
		// and the byte after the result is dropped
		put_byte(8'h41, 1'b0, 1'b0, 16'd0);
		put_byte(8'h00, 1'b0, 1'b0, 16'd0);
		put_byte(8'hFF, 1'b0, 1'b1, 16'd0);
		settle();

		// "Cat", caseless, whole word
		load_regs(64'h746143, 64'd0, 5'd3, 1'b0, 1'b1);
		// blank on the right confirms; trailing byte dropped
		put_byte(8'h20, 1'b1, 1'b0, 16'd0);
		put_byte(8'h63, 1'b0, 1'b0, 16'd0);
		put_byte(8'h41, 1'b0, 1'b0, 16'd0);
		put_byte(8'h54, 1'b0, 1'b0, 16'd0);
		put_byte(8'h20, 1'b0, 1'b0, 16'd0);
		put_byte(8'h78, 1'b0, 1'b1, 16'd0);
		// pending right side broken by a letter, ends not found
		put_byte(8'h63, 1'b1, 1'b0, 16'd0);
		put_byte(8'h61, 1'b0, 1'b0, 16'd0);
		put_byte(8'h74, 1'b0, 1'b0, 16'd0);
		put_byte(8'h73, 1'b0, 1'b1, 16'd0);
		// start limit past the match
		put_byte(8'h43, 1'b1, 1'b0, 16'd1);
		put_byte(8'h41, 1'b0, 1'b0, 16'd0);
		put_byte(8'h54, 1'b0, 1'b1, 16'd0);
		// whole word closed by the text edge
		put_byte(8'h43, 1'b1, 1'b0, 16'd0);
		put_byte(8'h41, 1'b0, 1'b0, 16'd0);
		put_byte(8'h54, 1'b0, 1'b1, 16'd0);
		settle();

		// length zero acts as one; top start limit
		load_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b1, 1'b0);
		put_byte(8'hFE, 1'b1, 1'b0, 16'd0);
		put_byte(8'hFF, 1'b0, 1'b1, 16'd0);
		put_byte(8'hFF, 1'b1, 1'b1, 16'hFFFF);
		settle();

		// random texts under four idle/stall mixes, four settings each
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 55; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 55; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			for (int j = 0; j < 4; j++) begin
				settle();
				pick_setting(phase, j);
				target = bytes_searched + BYTES_PER_SET;
				while (bytes_searched < target)
					run_text();
			end
		end
		settle();

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/spm_pkg.sv
src/spm_window_cmp.sv
src/string_pattern_matcher_core.sv
tb/match_checker.sv
tb/testbench.sv
